@@ hw/rtl/mcpg_pkg.sv @@
// Package for the midpoint circle point generator.
// Shared types, mode codes and arithmetic constants; no dependencies.
`default_nettype none

package mcpg_pkg;

	typedef logic [15:0] color_t;
	typedef logic [7:0]  cx_t;
	typedef logic [8:0]  cy_t;
	typedef logic [7:0]  offset_t;
	typedef logic [11:0] decision_t;

	// Command mode codes
	localparam logic MODE_START = 1'b0;
	localparam logic MODE_CONT  = 1'b1;

	// Decision constants of the midpoint recurrence
	localparam decision_t DEC_INIT     = 12'd3;
	localparam decision_t DEC_STEP_NEG = 12'd6;
	localparam decision_t DEC_STEP_POS = 12'd10;

	// Points per octant set and set-descriptor queue depth
	localparam int POINTS_PER_SET = 8;
	localparam int IDX_W          = $clog2(POINTS_PER_SET);
	localparam int QUEUE_DEPTH    = 2;

	// Default coordinate widths
	localparam int X_BITS_DEF = 8;
	localparam int Y_BITS_DEF = 9;

	// One octant set: center, offsets, color and end-of-circle flag
	typedef struct packed {
		cx_t     cx;
		cy_t     cy;
		offset_t xo;
		offset_t yo;
		color_t  color;
		logic    fin;
	} set_t;

endpackage

`default_nettype wire

@@ hw/rtl/mcpg_in_if.sv @@
// Command channel interface of the midpoint circle point generator.
// Depends on mcpg_pkg.
`default_nettype none

interface mcpg_in_if;
	logic           valid;
	logic           ready;
	logic           mode;
	mcpg_pkg::cx_t  center_x;
	mcpg_pkg::cy_t  center_y;
	mcpg_pkg::offset_t radius;

	modport source (output valid, output mode, output center_x, output center_y,
		output radius, input ready);
	modport sink (input valid, input mode, input center_x, input center_y,
		input radius, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/mcpg_out_if.sv @@
// Point channel interface of the midpoint circle point generator.
// Depends on mcpg_pkg; widths follow X_BITS and Y_BITS.
`default_nettype none

interface mcpg_out_if #(
	parameter int X_BITS = mcpg_pkg::X_BITS_DEF,
	parameter int Y_BITS = mcpg_pkg::Y_BITS_DEF
);
	logic                valid;
	logic                ready;
	logic [X_BITS-1:0]   point_x;
	logic [Y_BITS-1:0]   point_y;
	mcpg_pkg::color_t    color;
	logic                last;

	modport source (output valid, output point_x, output point_y, output color,
		output last, input ready);
	modport sink (input valid, input point_x, input point_y, input color,
		input last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/mcpg_front.sv @@
// Front end: accepts commands, holds circle state and color register,
// runs one midpoint step per set. Depends on mcpg_pkg and mcpg_in_if.
`default_nettype none

module mcpg_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_wr_en,
	input  wire mcpg_pkg::color_t cfg_wr_data,
	mcpg_in_if.sink             cmd,
	input  wire logic           q_full,
	output logic                q_push,
	output mcpg_pkg::set_t      q_data
);
	import mcpg_pkg::*;

	color_t    color_q;
	cx_t       cx_q;
	cy_t       cy_q;
	offset_t   xo_q;
	offset_t   yo_q;
	decision_t dec_q;
	logic      active_q;

	logic      start;
	cx_t       cur_cx;
	cy_t       cur_cy;
	offset_t   cur_xo;
	offset_t   cur_yo;
	decision_t cur_dec;
	decision_t nxt_dec;
	offset_t   nxt_xo;
	offset_t   nxt_yo;
	logic      y_end;
	logic      done;

	assign cmd.ready = !q_full;
	assign start     = (cmd.mode == MODE_START);

	always_comb begin
		cur_cx  = start ? cmd.center_x : cx_q;
		cur_cy  = start ? cmd.center_y : cy_q;
		cur_xo  = start ? '0 : xo_q;
		cur_yo  = start ? cmd.radius : yo_q;
		cur_dec = start ? (DEC_INIT - {3'b000, cmd.radius, 1'b0}) : dec_q;

		// sign bit of the 12-bit decision picks the step
		if (cur_dec[11]) begin
			nxt_dec = cur_dec + {2'b00, cur_xo, 2'b00} + DEC_STEP_NEG;
			nxt_yo  = cur_yo;
			y_end   = 1'b0;
		end else begin
			nxt_dec = cur_dec + {2'b00, cur_xo, 2'b00} - {2'b00, cur_yo, 2'b00}
				+ DEC_STEP_POS;
			y_end   = (cur_yo == '0);
			nxt_yo  = y_end ? cur_yo : cur_yo - 8'd1;
		end
		nxt_xo = cur_xo + 8'd1;
		done   = y_end || (nxt_xo > nxt_yo) || (nxt_xo == '0);
	end

	assign q_push = cmd.valid && cmd.ready && (start || active_q);

	always_comb begin
		q_data.cx    = cur_cx;
		q_data.cy    = cur_cy;
		q_data.xo    = cur_xo;
		q_data.yo    = cur_yo;
		q_data.color = color_q;
		q_data.fin   = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q  <= '0;
			cx_q     <= '0;
			cy_q     <= '0;
			xo_q     <= '0;
			yo_q     <= '0;
			dec_q    <= '0;
			active_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				color_q <= cfg_wr_data;
			end
			if (q_push) begin
				cx_q     <= cur_cx;
				cy_q     <= cur_cy;
				xo_q     <= nxt_xo;
				yo_q     <= nxt_yo;
				dec_q    <= nxt_dec;
				active_q <= !done;
			end
		end
	end

	// a continue with no circle in progress must not reach the queue
	a_no_idle_push: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.mode == MODE_CONT && !active_q) |-> !q_push)
		else $error("continue pushed without active circle");
	// a finished set clears the circle
	a_fin_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && q_data.fin) |=> !active_q)
		else $error("circle still active after final set");
	// offsets never cross while a circle is in progress
	a_offsets_order: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (xo_q <= yo_q))
		else $error("x offset passed y offset on active circle");

endmodule

`default_nettype wire

@@ hw/rtl/mcpg_queue.sv @@
// Short FIFO of octant-set descriptors between front and back end.
// Depends on mcpg_pkg.
`default_nettype none

module mcpg_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire mcpg_pkg::set_t push_data,
	input  wire logic           pop,
	output logic                full,
	output logic                not_empty,
	output mcpg_pkg::set_t      head
);
	import mcpg_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	set_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

`default_nettype wire

@@ hw/rtl/mcpg_back.sv @@
// Back end: walks the eight octant points of the head set into the
// output register. Depends on mcpg_pkg and mcpg_out_if.
`default_nettype none

module mcpg_back #(
	parameter int X_BITS = mcpg_pkg::X_BITS_DEF,
	parameter int Y_BITS = mcpg_pkg::Y_BITS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	input  wire mcpg_pkg::set_t q_data,
	output logic                q_pop,
	mcpg_out_if.source          pnt
);
	import mcpg_pkg::*;

	localparam int XW = (X_BITS > 8) ? X_BITS : 8;
	localparam int YW = (Y_BITS > 9) ? Y_BITS : 9;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(POINTS_PER_SET - 1);

	logic [IDX_W-1:0]  idx_q;
	logic              valid_q;
	logic [X_BITS-1:0] px_q;
	logic [Y_BITS-1:0] py_q;
	color_t            color_q;
	logic              last_q;

	logic              load;
	offset_t           x_off;
	offset_t           y_off;
	logic [XW-1:0]     x_full;
	logic [YW-1:0]     y_full;

	assign load  = q_valid && (!valid_q || pnt.ready);
	assign q_pop = load && (idx_q == IDX_LAST);

	// bit 2 swaps offsets, bit 1 negates x, bit 0 negates y
	always_comb begin
		x_off  = idx_q[2] ? q_data.yo : q_data.xo;
		y_off  = idx_q[2] ? q_data.xo : q_data.yo;
		x_full = idx_q[1] ? (XW'(q_data.cx) - XW'(x_off)) : (XW'(q_data.cx) + XW'(x_off));
		y_full = idx_q[0] ? (YW'(q_data.cy) - YW'(y_off)) : (YW'(q_data.cy) + YW'(y_off));
	end

	always_ff @(posedge clk) begin
		if (load) begin
			px_q    <= x_full[X_BITS-1:0];
			py_q    <= y_full[Y_BITS-1:0];
			color_q <= q_data.color;
			last_q  <= q_data.fin && (idx_q == IDX_LAST);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q   <= idx_q + 1'b1;
				valid_q <= 1'b1;
			end else if (pnt.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign pnt.valid   = valid_q;
	assign pnt.point_x = px_q;
	assign pnt.point_y = py_q;
	assign pnt.color   = color_q;
	assign pnt.last    = last_q;

	// a set is held at the queue head until all eight points are out
	a_head_held: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != '0) |-> q_valid)
		else $error("set left queue mid-walk");
	// a stalled output freezes the point index
	a_stall_holds_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !pnt.ready) |=> $stable(idx_q))
		else $error("point index moved under stall");
	// the flagged point is always the eighth of its set
	a_last_position: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && last_q) |-> (idx_q == '0))
		else $error("last flag on wrong point");

endmodule

`default_nettype wire

@@ hw/rtl/midpoint_circle_point_generator_unit.sv @@
// Top level of the midpoint circle point generator.
// Depends on mcpg_pkg, mcpg_in_if, mcpg_out_if, mcpg_front, mcpg_queue, mcpg_back.
//
// Usage:
//   cmd  (valid/ready): one transaction per command. mode = start loads
//        center_x, center_y and radius and produces the first octant set;
//        mode = continue produces the next set of the circle in progress.
//        A continue with no circle in progress is consumed and yields nothing.
//   pnt  (valid/ready): eight point transactions per set, in octant order,
//        each tagged with the foreground color; last marks the final point
//        of the whole circle.
//   cfg_wr_en / cfg_wr_data: writes the foreground color (write while idle).
// Order: with the back end idle, a set pushed into the queue by the command
//   transaction yields its first point in the output register, built from the
//   queue head; the remaining seven follow one per cycle while pnt.ready is high.
// Throughput: bound by the point channel, which moves one point per cycle
//   while the receiver is ready. A two-entry set queue lets the front take
//   commands while the back is still walking earlier sets.
// Receiver stall: the output register holds its point; once the queue fills,
//   cmd.ready drops. Nothing is lost or repeated.
// Reset: arst_n clears the color to 0, drops any circle in progress and
//   empties the queue and the output register.
`default_nettype none

module midpoint_circle_point_generator_unit #(
	parameter int X_BITS = mcpg_pkg::X_BITS_DEF,
	parameter int Y_BITS = mcpg_pkg::Y_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire mcpg_pkg::color_t cfg_wr_data,
	mcpg_in_if.sink               cmd,
	mcpg_out_if.source            pnt
);
	import mcpg_pkg::*;

	// front -> queue
	logic q_push;
	set_t q_push_data;
	logic q_full;

	// queue -> back
	logic q_pop;
	logic q_not_empty;
	set_t q_head;

	mcpg_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_push_data)
	);

	mcpg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	mcpg_back #(
		.X_BITS (X_BITS),
		.Y_BITS (Y_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_not_empty),
		.q_data  (q_head),
		.q_pop   (q_pop),
		.pnt     (pnt)
	);

endmodule

`default_nettype wire
